### src/ple_pkg.sv
// Shared constants and codes of the positional list engine.
`default_nettype none
package ple_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 8;
  localparam int ACT_W   = 2;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 6;

  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SORT     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ_ALL = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

endpackage
`default_nettype wire

### src/ple_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### src/positional_list_engine_unit.sv
// Positional list engine: ordered list of signed words with insert, delete, sort and read-out.
//
// The list lives in one RAM with a single write port and a single registered read port,
// and a small sequencer walks it; the RAM port sets all timings, and the block takes no
// new beat until the current action is finished. Insert at position p moves each entry
// from the end down to p back by one slot, a read and then a write each, and then writes
// the new item; delete at position p reads that entry, then moves each later entry forward
// by one slot, a read and then a write each; sort compares each entry with every later
// one, and read-all reads the entries in order and loads a result beat for each. Errors,
// the empty cases and a sort of fewer than two entries go straight to the result. A result
// beat waits while the result register still holds a stalled beat, and the next input beat
// is taken in the cycle after the final result beat is loaded. A finished result sits in an
// output register, so the next input beat is taken while that result is still stalled.
// Out-of-range positions report bad position, an insert into a full list reports full, and
// entry_count carries the low six bits of the count after the action.
`default_nettype none
module positional_list_engine_unit #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [ple_pkg::ACT_W-1:0]        action_i,
  input  wire logic [ple_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [ple_pkg::DATA_W-1:0] item_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [ple_pkg::ST_W-1:0]              status_o,
  output logic signed [ple_pkg::DATA_W-1:0]     out_value_o,
  output logic [ple_pkg::COUNT_W-1:0]           entry_count_o,
  output logic                                  last_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
  localparam int DW    = ple_pkg::DATA_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EMIT    = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_INS_NEW = 4'd4;
  localparam logic [3:0] S_DEL_GET = 4'd5;
  localparam logic [3:0] S_DEL_CAP = 4'd6;
  localparam logic [3:0] S_DEL_RD  = 4'd7;
  localparam logic [3:0] S_DEL_WR  = 4'd8;
  localparam logic [3:0] S_SRT_RI  = 4'd9;
  localparam logic [3:0] S_SRT_CI  = 4'd10;
  localparam logic [3:0] S_SRT_RJ  = 4'd11;
  localparam logic [3:0] S_SRT_CJ  = 4'd12;
  localparam logic [3:0] S_SRT_WI  = 4'd13;
  localparam logic [3:0] S_RD_RD   = 4'd14;
  localparam logic [3:0] S_RD_EM   = 4'd15;

  logic [3:0]             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]       j_q, j_d;
  logic [IDX_W-1:0]       tgt_q, tgt_d;
  logic [DW-1:0]          val_q, val_d;
  logic [DW-1:0]          cur_q, cur_d;
  logic [ple_pkg::ST_W-1:0] st_q, st_d;
  logic [DW-1:0]          ov_q, ov_d;

  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [DW-1:0]          ram_wdata, ram_rdata;

  logic                   emit_go, emit_last;
  logic [ple_pkg::ST_W-1:0] emit_st;
  logic [DW-1:0]          emit_val;

  logic                   out_valid_q;
  logic [ple_pkg::ST_W-1:0] status_q;
  logic [DW-1:0]          value_q;
  logic [ple_pkg::COUNT_W-1:0] cnt_out_q;
  logic                   last_q;
  logic                   out_free;

  logic [CMP_W-1:0]       pos_w, cnt_w, i_w, j_w;

  assign pos_w    = CMP_W'(position_i);
  assign cnt_w    = CMP_W'(count_q);
  assign i_w      = CMP_W'(i_q);
  assign j_w      = CMP_W'(j_q);
  assign out_free = !out_valid_q || !out_stall_i;

  ple_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    tgt_d     = tgt_q;
    val_d     = val_q;
    cur_d     = cur_q;
    st_d      = st_q;
    ov_d      = ov_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    emit_go   = 1'b0;
    emit_st   = st_q;
    emit_val  = ov_q;
    emit_last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ov_d  = '0;
          st_d  = ple_pkg::ST_OK;
          val_d = item_value_i;
          case (action_i)
            ple_pkg::ACT_INSERT: begin
              if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
                st_d    = ple_pkg::ST_BADPOS;
                state_d = S_EMIT;
              end else if (cnt_w == CMP_W'(CAPACITY)) begin
                st_d    = ple_pkg::ST_FULL;
                state_d = S_EMIT;
              end else begin
                tgt_d = IDX_W'(pos_w - 1'b1);
                i_d   = count_q;
                // Entries at and after the target slot move back by one first.
                if (cnt_w > pos_w - 1'b1) begin
                  state_d = S_INS_RD;
                end else begin
                  state_d = S_INS_NEW;
                end
              end
            end
            ple_pkg::ACT_DELETE: begin
              if (count_q == '0) begin
                st_d    = ple_pkg::ST_EMPTY;
                state_d = S_EMIT;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                st_d    = ple_pkg::ST_BADPOS;
                state_d = S_EMIT;
              end else begin
                i_d     = CNT_W'(pos_w - 1'b1);
                state_d = S_DEL_GET;
              end
            end
            ple_pkg::ACT_SORT: begin
              i_d = '0;
              if (cnt_w > CMP_W'(1)) begin
                state_d = S_SRT_RI;
              end else begin
                state_d = S_EMIT;
              end
            end
            default: begin
              i_d = '0;
              if (count_q == '0) begin
                st_d    = ple_pkg::ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                state_d = S_RD_RD;
              end
            end
          endcase
        end
      end

      S_EMIT: begin
        emit_go = out_free;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      S_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(i_q - 1'b1);
        state_d   = S_INS_WR;
      end

      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(i_q);
        ram_wdata = ram_rdata;
        i_d       = i_q - 1'b1;
        if (i_w - 1'b1 > CMP_W'(tgt_q)) begin
          state_d = S_INS_RD;
        end else begin
          state_d = S_INS_NEW;
        end
      end

      S_INS_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_q;
        ram_wdata = val_q;
        count_d   = count_q + 1'b1;
        state_d   = S_EMIT;
      end

      S_DEL_GET: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(i_q);
        state_d   = S_DEL_CAP;
      end

      S_DEL_CAP: begin
        ov_d = ram_rdata;
        if (i_w + 1'b1 < cnt_w) begin
          state_d = S_DEL_RD;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_EMIT;
        end
      end

      S_DEL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(i_q + 1'b1);
        state_d   = S_DEL_WR;
      end

      S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(i_q);
        ram_wdata = ram_rdata;
        i_d       = i_q + 1'b1;
        if (i_w + 2'd2 < cnt_w) begin
          state_d = S_DEL_RD;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_EMIT;
        end
      end

      // Exchange sort: cur_q carries entry i while every later entry is compared against it.
      S_SRT_RI: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(i_q);
        state_d   = S_SRT_CI;
      end

      S_SRT_CI: begin
        cur_d   = ram_rdata;
        j_d     = i_q + 1'b1;
        state_d = S_SRT_RJ;
      end

      S_SRT_RJ: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(j_q);
        state_d   = S_SRT_CJ;
      end

      S_SRT_CJ: begin
        if ($signed(cur_q) > $signed(ram_rdata)) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(j_q);
          ram_wdata = cur_q;
          cur_d     = ram_rdata;
        end
        j_d = j_q + 1'b1;
        if (j_w + 1'b1 < cnt_w) begin
          state_d = S_SRT_RJ;
        end else begin
          state_d = S_SRT_WI;
        end
      end

      S_SRT_WI: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(i_q);
        ram_wdata = cur_q;
        i_d       = i_q + 1'b1;
        if (i_w + 2'd2 < cnt_w) begin
          state_d = S_SRT_RI;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_RD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(i_q);
        state_d   = S_RD_EM;
      end

      S_RD_EM: begin
        // The read data register holds its entry until the beat is taken.
        emit_go   = out_free;
        emit_st   = ple_pkg::ST_OK;
        emit_val  = ram_rdata;
        emit_last = (i_w + 1'b1 == cnt_w);
        if (out_free) begin
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_RD_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    tgt_q <= tgt_d;
    val_q <= val_d;
    cur_q <= cur_d;
    st_q  <= st_d;
    ov_q  <= ov_d;
    if (emit_go) begin
      status_q  <= emit_st;
      value_q   <= emit_val;
      cnt_out_q <= ple_pkg::COUNT_W'(count_q);
      last_q    <= emit_last;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_value_o   = value_q;
  assign entry_count_o = cnt_out_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire
